@@ sv/psbb_pkg.sv @@
// shared constants, types and helper functions for the parabola bounding box core
package psbb_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS     = 16;
  localparam int LEN_BITS      = WORD_BITS - 1;
  localparam int THR_BITS      = 16;
  localparam int THR_RESET     = 1;
  localparam int AXES          = 3;
  localparam int POINTS        = AXES + 1;
  localparam int MAG_BITS      = WORD_BITS;
  localparam int NUM_BITS      = MAG_BITS + FRAC_BITS;
  localparam int QUO_BITS      = LEN_BITS;
  localparam int REM_BITS      = MAG_BITS;
  localparam int PROD_BITS     = MAG_BITS + LEN_BITS;
  localparam int PRODQ_BITS    = PROD_BITS - FRAC_BITS;
  localparam int SPLIT_BITS    = (PRODQ_BITS + 1) / 2;
  localparam int ATT_FULL_BITS = PRODQ_BITS + LEN_BITS;
  localparam int ATT_BITS      = ATT_FULL_BITS - FRAC_BITS - 1;
  localparam int ACC_BITS      = 64;
  localparam int EVAL_LAT      = 4;
  localparam int MERGE_LAT     = 3;
  localparam int PIPE_STAGES   = 3 + QUO_BITS + EVAL_LAT + MERGE_LAT + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [LEN_BITS-1:0]         len_t;
  typedef logic [MAG_BITS-1:0]         mag_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  typedef struct {
    word_t org [AXES];
    word_t spd [AXES];
    word_t acc [AXES];
    len_t  len;
    len_t  lw;
  } seg_t;

  function automatic mag_t mag_of(word_t x);
    return x[WORD_BITS-1] ? MAG_BITS'(~x + 1'b1) : MAG_BITS'(x);
  endfunction

  function automatic word_t sat_word(acc_t x);
    acc_t hi_lim;
    acc_t lo_lim;
    hi_lim = ACC_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
    lo_lim = ~hi_lim;
    if (x > hi_lim) begin
      return hi_lim[WORD_BITS-1:0];
    end else if (x < lo_lim) begin
      return lo_lim[WORD_BITS-1:0];
    end
    return x[WORD_BITS-1:0];
  endfunction

endpackage

@@ sv/psbb_if.sv @@
// segment and box channel interfaces
interface psbb_seg_if import psbb_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t origin_x;
  word_t origin_y;
  word_t origin_z;
  word_t speed_x;
  word_t speed_y;
  word_t speed_z;
  word_t accel_x;
  word_t accel_y;
  word_t accel_z;
  len_t  path_length;
  len_t  line_width;

  modport source (
    output valid, origin_x, origin_y, origin_z, speed_x, speed_y, speed_z,
    output accel_x, accel_y, accel_z, path_length, line_width,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, speed_x, speed_y, speed_z,
    input  accel_x, accel_y, accel_z, path_length, line_width,
    output ready
  );
endinterface

interface psbb_box_if import psbb_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t box_min_x;
  word_t box_min_y;
  word_t box_min_z;
  word_t box_max_x;
  word_t box_max_y;
  word_t box_max_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

@@ sv/psbb_eval.sv @@
// four stage pipelined evaluation of o + v*t + a*t*t/2 on one axis
module psbb_eval import psbb_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t org,
  input  word_t spd,
  input  word_t acc,
  input  len_t  t,
  output acc_t  pos
);

  localparam int QLO_BITS = SPLIT_BITS + LEN_BITS;
  localparam int QHI_BITS = PRODQ_BITS - SPLIT_BITS + LEN_BITS;

  logic [PROD_BITS-1:0] pv1_r;
  logic [PROD_BITS-1:0] pa1_r;
  logic                 sv1_r;
  logic                 sa1_r;
  len_t                 t1_r;
  word_t                o1_r;

  logic [PRODQ_BITS-1:0] vt2_r;
  logic [QLO_BITS-1:0]   qlo2_r;
  logic [QHI_BITS-1:0]   qhi2_r;
  logic                  sv2_r;
  logic                  sa2_r;
  word_t                 o2_r;

  acc_t  vt3_r;
  acc_t  att3_r;
  word_t o3_r;

  acc_t pos_r;

  logic [PRODQ_BITS-1:0]    atq;
  logic [ATT_FULL_BITS-1:0] att_full;
  logic [ATT_BITS-1:0]      att_mag;
  acc_t                     vt_u;
  acc_t                     att_u;

  always_comb begin
    atq      = pa1_r[PROD_BITS-1:FRAC_BITS];
    att_full = (ATT_FULL_BITS'(qhi2_r) << SPLIT_BITS) + ATT_FULL_BITS'(qlo2_r);
    att_mag  = att_full[ATT_FULL_BITS-1:FRAC_BITS+1];
    vt_u     = ACC_BITS'(vt2_r);
    att_u    = ACC_BITS'(att_mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes times t
      pv1_r  <= PROD_BITS'(mag_of(spd)) * PROD_BITS'(t);
      pa1_r  <= PROD_BITS'(mag_of(acc)) * PROD_BITS'(t);
      sv1_r  <= spd[WORD_BITS-1];
      sa1_r  <= acc[WORD_BITS-1];
      t1_r   <= t;
      o1_r   <= org;
      // second product split in two halves
      vt2_r  <= pv1_r[PROD_BITS-1:FRAC_BITS];
      qlo2_r <= QLO_BITS'(atq[SPLIT_BITS-1:0]) * QLO_BITS'(t1_r);
      qhi2_r <= QHI_BITS'(atq[PRODQ_BITS-1:SPLIT_BITS]) * QHI_BITS'(t1_r);
      sv2_r  <= sv1_r;
      sa2_r  <= sa1_r;
      o2_r   <= o1_r;
      // signs back on
      vt3_r  <= sv2_r ? -vt_u : vt_u;
      att3_r <= sa2_r ? -att_u : att_u;
      o3_r   <= o2_r;
      pos_r  <= ACC_BITS'(o3_r) + vt3_r + att3_r;
    end
  end

  assign pos = pos_r;

endmodule

@@ sv/parabola_segment_bounding_box_core.sv @@
// parabola segment bounding box core
// throughput: one segment per cycle; a 31 step pipelined divider and 12 axis evaluators
// set the depth, the whole pipeline holds while the output word is stalled
// reset: synchronous active low, clears all valid bits and sets the threshold to 1
module parabola_segment_bounding_box_core import psbb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [THR_BITS-1:0] cfg_wr_data,
  psbb_seg_if.sink            in_ch,
  psbb_box_if.source          out_ch
);

  typedef struct {
    word_t                org [AXES];
    logic [AXES-1:0]      qual;
    logic [LEN_BITS-2:0]  hw;
  } tail_t;

  function automatic acc_t amin(acc_t a, acc_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic acc_t amax(acc_t a, acc_t b);
    return (a > b) ? a : b;
  endfunction

  logic [THR_BITS-1:0]    thr_r;
  logic [PIPE_STAGES-1:0] vld_r;
  logic                   adv;

  assign adv         = !vld_r[PIPE_STAGES-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= THR_BITS'(THR_RESET);
    end else begin
      if (adv) begin
        vld_r <= {vld_r[PIPE_STAGES-2:0], in_ch.valid};
      end
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // input register
  seg_t seg0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      seg0_r.org[0] <= in_ch.origin_x;
      seg0_r.org[1] <= in_ch.origin_y;
      seg0_r.org[2] <= in_ch.origin_z;
      seg0_r.spd[0] <= in_ch.speed_x;
      seg0_r.spd[1] <= in_ch.speed_y;
      seg0_r.spd[2] <= in_ch.speed_z;
      seg0_r.acc[0] <= in_ch.accel_x;
      seg0_r.acc[1] <= in_ch.accel_y;
      seg0_r.acc[2] <= in_ch.accel_z;
      seg0_r.len    <= in_ch.path_length;
      seg0_r.lw     <= in_ch.line_width;
    end
  end

  // threshold, sign and end limit products
  seg_t                 seg1_r;
  logic [PROD_BITS-1:0] lim1_r [AXES];
  logic [AXES-1:0]      thr1_r;
  logic [AXES-1:0]      opp1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      seg1_r <= seg0_r;
      for (int k = 0; k < AXES; k++) begin
        lim1_r[k] <= PROD_BITS'(seg0_r.len) * PROD_BITS'(mag_of(seg0_r.acc[k]));
        thr1_r[k] <= (mag_of(seg0_r.spd[k]) > MAG_BITS'(thr_r)) &&
                     (mag_of(seg0_r.acc[k]) > MAG_BITS'(thr_r));
        opp1_r[k] <= seg0_r.spd[k][WORD_BITS-1] != seg0_r.acc[k][WORD_BITS-1];
      end
    end
  end

  // turning time divider, one quotient bit per stage
  seg_t                segd_r [QUO_BITS+1];
  logic [AXES-1:0]     qpre_r [QUO_BITS+1];
  logic [REM_BITS-1:0] rem_r  [QUO_BITS+1][AXES];
  logic [QUO_BITS-1:0] quo_r  [QUO_BITS+1][AXES];
  logic [NUM_BITS-1:0] num_r  [QUO_BITS+1][AXES];
  mag_t                den_r  [QUO_BITS+1][AXES];
  logic [NUM_BITS-1:0] num1   [AXES];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      num1[k] = {mag_of(seg1_r.spd[k]), {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      segd_r[0] <= seg1_r;
      for (int k = 0; k < AXES; k++) begin
        qpre_r[0][k] <= thr1_r[k] && opp1_r[k] && (PROD_BITS'(num1[k]) < lim1_r[k]);
        rem_r[0][k]  <= REM_BITS'(num1[k] >> QUO_BITS);
        quo_r[0][k]  <= '0;
        num_r[0][k]  <= num1[k];
        den_r[0][k]  <= mag_of(seg1_r.acc[k]);
      end
    end
  end

  for (genvar j = 1; j <= QUO_BITS; j++) begin : g_div
    localparam int B = QUO_BITS - j;
    for (genvar k = 0; k < AXES; k++) begin : g_ax
      logic [REM_BITS:0]   sh;
      logic [REM_BITS:0]   diff;
      logic [QUO_BITS-1:0] quo_nxt;

      always_comb begin
        sh         = {rem_r[j-1][k], num_r[j-1][k][B]};
        diff       = sh - {1'b0, den_r[j-1][k]};
        quo_nxt    = quo_r[j-1][k];
        quo_nxt[B] = ~diff[REM_BITS];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j][k] <= diff[REM_BITS] ? sh[REM_BITS-1:0] : diff[REM_BITS-1:0];
          quo_r[j][k] <= quo_nxt;
          num_r[j][k] <= num_r[j-1][k];
          den_r[j][k] <= den_r[j-1][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        segd_r[j] <= segd_r[j-1];
        qpre_r[j] <= qpre_r[j-1];
      end
    end
  end

  // end point and the three turning points, every axis
  acc_t pt [POINTS][AXES];

  for (genvar s = 0; s < POINTS; s++) begin : g_pt
    for (genvar k = 0; k < AXES; k++) begin : g_ax
      len_t t_sel;
      if (s == 0) begin : g_end
        assign t_sel = segd_r[QUO_BITS].len;
      end else begin : g_turn
        assign t_sel = LEN_BITS'(quo_r[QUO_BITS][s-1]);
      end
      psbb_eval u_eval (
        .clk (clk),
        .en  (adv),
        .org (segd_r[QUO_BITS].org[k]),
        .spd (segd_r[QUO_BITS].spd[k]),
        .acc (segd_r[QUO_BITS].acc[k]),
        .t   (t_sel),
        .pos (pt[s][k])
      );
    end
  end

  tail_t tail_r [EVAL_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < AXES; k++) begin
        tail_r[0].org[k]  <= segd_r[QUO_BITS].org[k];
        tail_r[0].qual[k] <= qpre_r[QUO_BITS][k] && (quo_r[QUO_BITS][k] != '0);
      end
      tail_r[0].hw <= segd_r[QUO_BITS].lw[LEN_BITS-1:1];
      for (int i = 1; i < EVAL_LAT; i++) begin
        tail_r[i] <= tail_r[i-1];
      end
    end
  end

  // min and max merge tree
  acc_t                cand   [POINTS][AXES];
  acc_t                loa1_r [AXES];
  acc_t                lob1_r [AXES];
  acc_t                loc1_r [AXES];
  acc_t                hia1_r [AXES];
  acc_t                hib1_r [AXES];
  acc_t                hic1_r [AXES];
  acc_t                lo2a_r [AXES];
  acc_t                lo2c_r [AXES];
  acc_t                hi2a_r [AXES];
  acc_t                hi2c_r [AXES];
  acc_t                lo3_r  [AXES];
  acc_t                hi3_r  [AXES];
  logic [LEN_BITS-2:0] hw1_r;
  logic [LEN_BITS-2:0] hw2_r;
  logic [LEN_BITS-2:0] hw3_r;
  acc_t                hw_ext;
  word_t               bmin_r [AXES];
  word_t               bmax_r [AXES];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      cand[0][k] = ACC_BITS'(tail_r[EVAL_LAT-1].org[k]);
      for (int s = 1; s < POINTS; s++) begin
        cand[s][k] = tail_r[EVAL_LAT-1].qual[s-1] ? pt[s][k] : cand[0][k];
      end
    end
    hw_ext = ACC_BITS'(hw3_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < AXES; k++) begin
        loa1_r[k] <= amin(cand[0][k], pt[0][k]);
        hia1_r[k] <= amax(cand[0][k], pt[0][k]);
        lob1_r[k] <= amin(cand[1][k], cand[2][k]);
        hib1_r[k] <= amax(cand[1][k], cand[2][k]);
        loc1_r[k] <= cand[3][k];
        hic1_r[k] <= cand[3][k];
        lo2a_r[k] <= amin(loa1_r[k], lob1_r[k]);
        hi2a_r[k] <= amax(hia1_r[k], hib1_r[k]);
        lo2c_r[k] <= loc1_r[k];
        hi2c_r[k] <= hic1_r[k];
        lo3_r[k]  <= amin(lo2a_r[k], lo2c_r[k]);
        hi3_r[k]  <= amax(hi2a_r[k], hi2c_r[k]);
        bmin_r[k] <= sat_word(lo3_r[k] - hw_ext);
        bmax_r[k] <= sat_word(hi3_r[k] + hw_ext);
      end
      hw1_r <= tail_r[EVAL_LAT-1].hw;
      hw2_r <= hw1_r;
      hw3_r <= hw2_r;
    end
  end

  assign out_ch.valid     = vld_r[PIPE_STAGES-1];
  assign out_ch.box_min_x = bmin_r[0];
  assign out_ch.box_min_y = bmin_r[1];
  assign out_ch.box_min_z = bmin_r[2];
  assign out_ch.box_max_x = bmax_r[0];
  assign out_ch.box_max_y = bmax_r[1];
  assign out_ch.box_max_z = bmax_r[2];

endmodule

@@ sv/psbb_checker.sv @@
// port level checks for the parabola bounding box core, bound to the top level
module psbb_checker import psbb_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t box_min_x,
  input word_t box_min_y,
  input word_t box_min_z,
  input word_t box_max_x,
  input word_t box_max_y,
  input word_t box_max_z
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled output word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(box_min_x) && $stable(box_min_y) &&
      $stable(box_min_z) && $stable(box_max_x) && $stable(box_max_y) &&
      $stable(box_max_z))
    else $error("stalled output word changed");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> box_min_x <= box_max_x && box_min_y <= box_max_y &&
      box_min_z <= box_max_z)
    else $error("box corners out of order");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input held off with a free output");

endmodule

bind parabola_segment_bounding_box_core psbb_checker u_psbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .box_min_x (out_ch.box_min_x),
  .box_min_y (out_ch.box_min_y),
  .box_min_z (out_ch.box_min_z),
  .box_max_x (out_ch.box_max_x),
  .box_max_y (out_ch.box_max_y),
  .box_max_z (out_ch.box_max_z)
);
